// File: rtl/core/power_channel_status_manager_core_macros.svh
// Assertion macros for the power channel status manager core.
// Used by the top level; no other dependencies.
`ifndef POWER_CHANNEL_STATUS_MANAGER_CORE_MACROS_SVH
`define POWER_CHANNEL_STATUS_MANAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PCSM_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pcsm: same-cycle check failed");
`define PCSM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pcsm: next-cycle check failed");
`else
`define PCSM_ASSERT_SAME(label, pre, post)
`define PCSM_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/core/pcsm_pkg.sv
// Shared types, constants and group tables for the power channel status manager.
// No dependencies.
package pcsm_pkg;

	localparam int NUM_CHANNELS = 20;
	localparam int CNT_W        = $clog2(NUM_CHANNELS);
	localparam int CHAN_W       = 5;
	localparam int FIELD_CH     = 20;
	localparam int CODES_W      = 2 * FIELD_CH;
	localparam int FB_W         = 20;
	localparam int MASK_W       = 20;
	localparam int FORCE_OFF_LIM = 16;
	localparam int NUM_GROUPS   = 5;
	localparam int GRP_W        = 3;
	localparam logic [GRP_W-1:0] NO_GROUP = 3'd5;

	typedef enum logic [2:0] {
		ST_OFF        = 3'd0,
		ST_ON         = 3'd1,
		ST_LOCK       = 3'd2,
		ST_SHORT      = 3'd3,
		ST_TRIP       = 3'd4,
		ST_CLOSE_FAIL = 3'd5,
		ST_OPEN_FAIL  = 3'd6,
		ST_ERROR      = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		OP_FRAME      = 4'd0,
		OP_OVERLOAD   = 4'd1,
		OP_SHORT      = 4'd2,
		OP_ON         = 4'd3,
		OP_OFF        = 4'd4,
		OP_CLOSE_FAIL = 4'd5,
		OP_OPEN_FAIL  = 4'd6,
		OP_ERROR      = 4'd7,
		OP_PHASE      = 4'd8,
		OP_QUERY      = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		REG_GROUP_EN    = 3'd0,
		REG_CODE_RESET  = 3'd1,
		REG_CODE_LOCK   = 3'd2,
		REG_CODE_UNLOCK = 3'd3,
		REG_CODE_ON     = 3'd4,
		REG_CODE_OFF    = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WALK,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [CHAN_W-1:0] ch;
		logic [NUM_GROUPS-1:0] grp_en;
		logic [1:0]        code_rst;
		logic [1:0]        code_lck;
		logic [1:0]        code_unl;
		logic [1:0]        code_on;
		logic [1:0]        code_off;
	} ctl_t;

	// triplets 0-2, 3-5, 7-9, 10-12, 13-15
	function automatic logic [GRP_W-1:0] grp_of(logic [CHAN_W-1:0] k);
		logic [GRP_W-1:0] g;
		if (k <= 5'd2)
			g = 3'd0;
		else if (k <= 5'd5)
			g = 3'd1;
		else if (k == 5'd6)
			g = NO_GROUP;
		else if (k <= 5'd9)
			g = 3'd2;
		else if (k <= 5'd12)
			g = 3'd3;
		else if (k <= 5'd15)
			g = 3'd4;
		else
			g = NO_GROUP;
		return g;
	endfunction

	function automatic logic [CHAN_W-1:0] group_first(logic [GRP_W-1:0] g);
		logic [CHAN_W-1:0] f;
		unique case (g)
			3'd0: f = 5'd0;
			3'd1: f = 5'd3;
			3'd2: f = 5'd7;
			3'd3: f = 5'd10;
			3'd4: f = 5'd13;
			default: f = 5'd0;
		endcase
		return f;
	endfunction

endpackage

// File: rtl/core/power_channel_status_manager_core.sv
// A word is taken when idle, the status ring is walked one channel per cycle
// through the shared update unit, then the result is held until out_ready.
// A new word is taken only after the held result has been handed off.
// Throughput is set by the single channel update unit walking the rotating status ring.
// Reset (arst_n low, async): all channels off, config registers to defaults, sequencer idle.
// Depends on pcsm_pkg, pcsm_chan_unit and the assertion macro header.
`include "power_channel_status_manager_core_macros.svh"

module power_channel_status_manager_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [4:0]  wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [4:0]  channel,
	input  logic [39:0] reset_codes,
	input  logic [39:0] lock_codes,
	input  logic [39:0] output_codes,
	input  logic [19:0] feedback_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] drive_mask,
	output logic [2:0]  queried_status,
	output logic [19:0] accumulator_clear
);

	localparam int N = pcsm_pkg::NUM_CHANNELS;
	localparam logic [pcsm_pkg::CNT_W-1:0] LAST = pcsm_pkg::CNT_W'(N - 1);

	pcsm_pkg::seq_state_t state_q, state_nxt;

	logic [4:0] grp_en_q;
	logic [1:0] code_rst_q, code_lck_q, code_unl_q, code_on_q, code_off_q;

	logic [3:0]                    op_q;
	logic [pcsm_pkg::CHAN_W-1:0]   ch_q;
	logic [pcsm_pkg::CODES_W-1:0]  rst_sh_q, lck_sh_q, out_sh_q;
	logic [pcsm_pkg::FB_W-1:0]     fb_q;
	logic [pcsm_pkg::CNT_W-1:0]    cnt_q;
	pcsm_pkg::status_t             st_q [N];
	logic [N-1:0]                  drive_q;
	logic [N-1:0]                  clr_q;
	pcsm_pkg::status_t             query_q;

	logic accept, walk, last;
	pcsm_pkg::ctl_t    ctl;
	pcsm_pkg::status_t nxt_st;
	logic              nxt_clr;

	assign accept = in_valid && in_ready;
	assign last   = (cnt_q == LAST);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_en_q   <= 5'd0;
			code_rst_q <= 2'd1;
			code_lck_q <= 2'd1;
			code_unl_q <= 2'd2;
			code_on_q  <= 2'd1;
			code_off_q <= 2'd0;
		end else if (wr_en) begin
			unique case (pcsm_pkg::reg_index_t'(wr_index))
				pcsm_pkg::REG_GROUP_EN:    grp_en_q   <= wr_data;
				pcsm_pkg::REG_CODE_RESET:  code_rst_q <= wr_data[1:0];
				pcsm_pkg::REG_CODE_LOCK:   code_lck_q <= wr_data[1:0];
				pcsm_pkg::REG_CODE_UNLOCK: code_unl_q <= wr_data[1:0];
				pcsm_pkg::REG_CODE_ON:     code_on_q  <= wr_data[1:0];
				pcsm_pkg::REG_CODE_OFF:    code_off_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pcsm_pkg::SEQ_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pcsm_pkg::SEQ_IDLE: if (in_valid) state_nxt = pcsm_pkg::SEQ_WALK;
			pcsm_pkg::SEQ_WALK: if (last) state_nxt = pcsm_pkg::SEQ_DONE;
			pcsm_pkg::SEQ_DONE: if (out_ready) state_nxt = pcsm_pkg::SEQ_IDLE;
			default: state_nxt = pcsm_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		walk      = 1'b0;
		unique case (state_q)
			pcsm_pkg::SEQ_IDLE: in_ready  = 1'b1;
			pcsm_pkg::SEQ_WALK: walk      = 1'b1;
			pcsm_pkg::SEQ_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (accept)
			cnt_q <= '0;
		else if (walk)
			cnt_q <= cnt_q + 1'b1;
	end

	// word capture; command fields shift down two bits per channel
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			ch_q     <= channel;
			rst_sh_q <= reset_codes;
			lck_sh_q <= lock_codes;
			out_sh_q <= output_codes;
			fb_q     <= feedback_bits;
			query_q  <= pcsm_pkg::ST_OFF;
		end else if (walk) begin
			rst_sh_q <= {2'b00, rst_sh_q[pcsm_pkg::CODES_W-1:2]};
			lck_sh_q <= {2'b00, lck_sh_q[pcsm_pkg::CODES_W-1:2]};
			out_sh_q <= {2'b00, out_sh_q[pcsm_pkg::CODES_W-1:2]};
			if (pcsm_pkg::CHAN_W'(cnt_q) == ch_q)
				query_q <= nxt_st;
		end
	end

	always_ff @(posedge clk) begin
		if (walk) begin
			drive_q <= {(nxt_st == pcsm_pkg::ST_ON), drive_q[N-1:1]};
			clr_q   <= {nxt_clr, clr_q[N-1:1]};
		end
	end

	// status ring: channel 0 sits at the head, updated entry goes to the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				st_q[i] <= pcsm_pkg::ST_OFF;
		end else if (walk) begin
			for (int i = 0; i < N - 1; i++)
				st_q[i] <= st_q[i+1];
			st_q[N-1] <= nxt_st;
		end
	end

	always_comb begin
		ctl.op       = op_q;
		ctl.ch       = ch_q;
		ctl.grp_en   = grp_en_q;
		ctl.code_rst = code_rst_q;
		ctl.code_lck = code_lck_q;
		ctl.code_unl = code_unl_q;
		ctl.code_on  = code_on_q;
		ctl.code_off = code_off_q;
	end

	pcsm_chan_unit u_unit (
		.ctl       (ctl),
		.k         (pcsm_pkg::CHAN_W'(cnt_q)),
		.cur       (st_q[0]),
		.rst_field (rst_sh_q[1:0]),
		.lck_field (lck_sh_q[1:0]),
		.out_field (out_sh_q[1:0]),
		.fb        (fb_q),
		.nxt       (nxt_st),
		.clr       (nxt_clr)
	);

	assign drive_mask        = drive_q[pcsm_pkg::MASK_W-1:0];
	assign accumulator_clear = clr_q[pcsm_pkg::MASK_W-1:0];
	assign queried_status    = query_q;

	`PCSM_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
	`PCSM_ASSERT_NEXT(a_walk_starts, accept, walk && cnt_q == '0)
	`PCSM_ASSERT_NEXT(a_walk_ends, walk && last, out_valid)
	`PCSM_ASSERT_SAME(a_clr_frame_only, out_valid && op_q != pcsm_pkg::OP_FRAME,
		accumulator_clear == '0)

endmodule

// File: rtl/core/pcsm_chan_unit.sv
// Shared per-channel update unit: next status of one channel for the current word.
// Depends on pcsm_pkg.
module pcsm_chan_unit (
	input  pcsm_pkg::ctl_t                ctl,
	input  logic [pcsm_pkg::CHAN_W-1:0]   k,
	input  pcsm_pkg::status_t             cur,
	input  logic [1:0]                    rst_field,
	input  logic [1:0]                    lck_field,
	input  logic [1:0]                    out_field,
	input  logic [pcsm_pkg::FB_W-1:0]     fb,
	output pcsm_pkg::status_t             nxt,
	output logic                          clr
);

	logic [pcsm_pkg::GRP_W-1:0]  ch_grp;
	logic [pcsm_pkg::GRP_W-1:0]  k_grp;
	logic [pcsm_pkg::CHAN_W-1:0] first;
	logic                        disagree;
	logic                        ch_tied;
	logic                        k_tied;
	logic                        hit;

	always_comb begin
		ch_grp   = pcsm_pkg::grp_of(ctl.ch);
		k_grp    = pcsm_pkg::grp_of(k);
		first    = pcsm_pkg::group_first(k_grp);
		disagree = (fb[first] != fb[first + 5'd1]) || (fb[first] != fb[first + 5'd2]);
		ch_tied  = (ch_grp != pcsm_pkg::NO_GROUP) && ctl.grp_en[ch_grp];
		k_tied   = (k_grp != pcsm_pkg::NO_GROUP) && ctl.grp_en[k_grp];
		hit      = (k == ctl.ch);
	end

	always_comb begin
		nxt = cur;
		clr = 1'b0;
		unique case (pcsm_pkg::opcode_t'(ctl.op))
			pcsm_pkg::OP_FRAME: begin
				if (rst_field == ctl.code_rst) begin
					nxt = pcsm_pkg::ST_OFF;
					clr = 1'b1;
				end
				if (nxt != pcsm_pkg::ST_SHORT && nxt != pcsm_pkg::ST_TRIP) begin
					if (lck_field == ctl.code_lck)
						nxt = pcsm_pkg::ST_LOCK;
					else if (lck_field == ctl.code_unl)
						nxt = pcsm_pkg::ST_OFF;
				end
				if (nxt != pcsm_pkg::ST_SHORT && nxt != pcsm_pkg::ST_LOCK &&
				    nxt != pcsm_pkg::ST_TRIP) begin
					if (out_field == ctl.code_off)
						nxt = pcsm_pkg::ST_OFF;
					else if (out_field == ctl.code_on)
						nxt = pcsm_pkg::ST_ON;
					else if (k < 5'(pcsm_pkg::FORCE_OFF_LIM))
						nxt = pcsm_pkg::ST_OFF;
				end
			end
			pcsm_pkg::OP_OVERLOAD: begin
				// tied triplet trips as a whole
				if (ch_tied) begin
					if (k_grp == ch_grp)
						nxt = pcsm_pkg::ST_TRIP;
				end else if (hit) begin
					nxt = pcsm_pkg::ST_TRIP;
				end
			end
			pcsm_pkg::OP_SHORT:      if (hit) nxt = pcsm_pkg::ST_SHORT;
			pcsm_pkg::OP_ON:         if (hit) nxt = pcsm_pkg::ST_ON;
			pcsm_pkg::OP_OFF:        if (hit) nxt = pcsm_pkg::ST_OFF;
			pcsm_pkg::OP_CLOSE_FAIL: if (hit) nxt = pcsm_pkg::ST_CLOSE_FAIL;
			pcsm_pkg::OP_OPEN_FAIL:  if (hit) nxt = pcsm_pkg::ST_OPEN_FAIL;
			pcsm_pkg::OP_ERROR:      if (hit) nxt = pcsm_pkg::ST_ERROR;
			pcsm_pkg::OP_PHASE:      if (k_tied && disagree) nxt = pcsm_pkg::ST_ERROR;
			default: ;
		endcase
	end

endmodule
